[rtl/fau_pkg.sv]
// Package: shared constants, status codes and stage types for the float add/multiply unit.
`default_nettype none
package fau_pkg;
	localparam int unsigned FracBits = 23;
	localparam int unsigned ExpBias  = 127;
	localparam int unsigned ManWidth = 48;
	localparam int unsigned ExpWidth = 10;
	localparam logic [31:0] FracMask = 32'h007f_ffff;
	localparam logic [31:0] ExpMask  = 32'h7f80_0000;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_MUL = 1'b1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_OVER = 2'd1;
	localparam logic [1:0] STATUS_UNDER = 2'd2;

	// Raw mantissa/exponent beat between the arithmetic stage and the normalizer
	typedef struct packed {
		logic                       sgn;
		logic signed [ExpWidth-1:0] exp;
		logic [ManWidth-1:0]        man;
	} raw_t;
endpackage
`default_nettype wire

[rtl/float32_add_multiply_unit_top.sv]
// Top level: single-precision add/multiply with truncation, two-stage pipeline.
// The accepted start passes the stage 1 register and then the result register before the result_valid strobe.
// Throughput: one operation per cycle; busy is held low, start is taken every cycle.
// Stage 1 forms the aligned sum or 24x24 product; stage 2 normalizes and packs.
// Reset (arst_n low) clears the valid pipeline only; results in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module float32_add_multiply_unit_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         req_type,
	input  wire  [31:0] left_bits,
	input  wire  [31:0] right_bits,
	output logic        result_valid,
	output logic [31:0] result_bits,
	output logic [1:0]  range_status
);
	logic               a_sgn, b_sgn;
	logic signed [9:0]  a_exp, b_exp;
	logic [23:0]        a_man, b_man;
	logic               a_big;
	logic               big_sgn, sml_sgn;
	logic signed [9:0]  big_exp;
	logic [23:0]        big_man, sml_man;
	logic [9:0]         align_sh;
	logic [23:0]        sml_al;
	logic [47:0]        prod;
	fau_pkg::raw_t      raw_d, raw_s1;
	logic               vld_s1;
	logic [31:0]        res_d;
	logic [1:0]         st_d;

	assign busy = 1'b0;

	// Unpack with implied leading one
	assign a_sgn = left_bits[31];
	assign b_sgn = right_bits[31];
	assign a_exp = 10'(signed'({2'b00, left_bits[30:23]})) - 10'sd127;
	assign b_exp = 10'(signed'({2'b00, right_bits[30:23]})) - 10'sd127;
	assign a_man = {1'b1, left_bits[22:0]};
	assign b_man = {1'b1, right_bits[22:0]};

	// Magnitude order; right wins a full tie
	assign a_big    = (a_exp > b_exp) || ((a_exp == b_exp) && (a_man > b_man));
	assign big_sgn  = a_big ? a_sgn : b_sgn;
	assign sml_sgn  = a_big ? b_sgn : a_sgn;
	assign big_exp  = a_big ? a_exp : b_exp;
	assign big_man  = a_big ? a_man : b_man;
	assign sml_man  = a_big ? b_man : a_man;
	assign align_sh = 10'(big_exp - (a_big ? b_exp : a_exp));
	assign sml_al   = (align_sh >= 10'd24) ? 24'd0 : (sml_man >> align_sh[4:0]);

	assign prod = 48'(a_man) * 48'(b_man);

	// Arithmetic stage select
	always_comb begin
		if (req_type == fau_pkg::REQ_MUL) begin
			raw_d.sgn = a_sgn ^ b_sgn;
			raw_d.exp = a_exp + b_exp - 10'sd23;
			raw_d.man = prod;
		end else begin
			raw_d.sgn = big_sgn;
			raw_d.exp = big_exp;
			raw_d.man = (big_sgn == sml_sgn) ? 48'(big_man) + 48'(sml_al)
				: 48'(big_man) - 48'(sml_al);
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= raw_d;
	end

	fau_norm u_norm (
		.raw          (raw_s1),
		.result_bits  (res_d),
		.range_status (st_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_bits  <= res_d;
		range_status <= st_d;
	end

	// Checks
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 result_valid) else $error("result strobe missing");
	a_nostrobe: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> !result_valid) else $error("spurious result");
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && range_status == fau_pkg::STATUS_OVER) |-> result_bits[30:23] == 8'hff)
		else $error("overflow not saturated");
	a_under: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && range_status == fau_pkg::STATUS_UNDER) |-> result_bits[30:23] == 8'h00)
		else $error("underflow not saturated");
endmodule
`default_nettype wire

[rtl/fau_norm.sv]
// Normalizer: leading-one detect, truncating shift and exponent packing with saturation.
`default_nettype none
module fau_norm (
	input  wire fau_pkg::raw_t raw,
	output logic [31:0]        result_bits,
	output logic [1:0]         range_status
);
	logic [5:0]         lead;
	logic [5:0]         lsh;
	logic [47:0]        shifted;
	logic signed [11:0] biased;
	logic [7:0]         field;

	// Leading-one position, highest set bit wins
	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (raw.man[i]) lead = 6'(i);
		end
	end

	// Put the leading one at bit 47; fraction sits just below it
	assign lsh     = 6'd47 - lead;
	assign shifted = raw.man << lsh;
	assign biased  = 12'(raw.exp) + 12'(signed'({1'b0, lead}))
		+ 12'(fau_pkg::ExpBias) - 12'(fau_pkg::FracBits);

	// Saturate the exponent field and pack
	always_comb begin
		if (raw.man == '0) begin
			field        = 8'd0;
			range_status = fau_pkg::STATUS_OK;
			result_bits  = 32'd0;
		end else begin
			if (biased > 12'sd255) begin
				field        = 8'hff;
				range_status = fau_pkg::STATUS_OVER;
			end else if (biased < 12'sd0) begin
				field        = 8'h00;
				range_status = fau_pkg::STATUS_UNDER;
			end else begin
				field        = biased[7:0];
				range_status = fau_pkg::STATUS_OK;
			end
			result_bits = {raw.sgn, field, shifted[46:24]};
		end
	end
endmodule
`default_nettype wire

[sim/fau_checker.sv]
// Checker: watches accepted operations and result strobes, predicts and compares results.
`timescale 1ns / 1ps
module fau_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire         req_type,
	input  wire  [31:0] left_bits,
	input  wire  [31:0] right_bits,
	input  wire         result_valid,
	input  wire  [31:0] result_bits,
	input  wire  [1:0]  range_status,
	output int          fail_count,
	output int          pending
);
	typedef struct {
		logic [31:0] bits;
		logic [1:0]  status;
	} fp_result_t;

	fp_result_t expected_q[$];

	// Truncating single-precision add or multiply of two bit patterns
	function automatic fp_result_t fp_compute(logic op, logic [31:0] a, logic [31:0] b);
		fp_result_t res;
		logic       sa, sb, rs;
		int         ea, eb, re, lead, biased, d;
		logic [63:0] ma, mb, rm, big_m, small_m;
		logic       big_s, small_s;
		int         big_e, small_e;
		logic [7:0] field;
		sa = a[31];
		sb = b[31];
		ea = int'(a[30:23]) - int'(fau_pkg::ExpBias);
		eb = int'(b[30:23]) - int'(fau_pkg::ExpBias);
		ma = {40'd0, 1'b1, a[22:0]};
		mb = {40'd0, 1'b1, b[22:0]};
		if (op == fau_pkg::REQ_MUL) begin
			rs = sa ^ sb;
			re = ea + eb - int'(fau_pkg::FracBits);
			rm = ma * mb;
		end else begin
			// larger magnitude first; a full tie takes the right operand
			if (ea > eb || (ea == eb && ma > mb)) begin
				big_s = sa; big_e = ea; big_m = ma;
				small_s = sb; small_e = eb; small_m = mb;
			end else begin
				big_s = sb; big_e = eb; big_m = mb;
				small_s = sa; small_e = ea; small_m = ma;
			end
			d = big_e - small_e;
			small_m = (d >= 32) ? 64'd0 : (small_m >> d);
			rs = big_s;
			re = big_e;
			rm = (big_s == small_s) ? big_m + small_m : big_m - small_m;
		end
		// exact cancellation
		if (rm == 0) begin
			res.bits = 32'd0;
			res.status = fau_pkg::STATUS_OK;
			return res;
		end
		lead = 63;
		while (lead > 0 && rm[lead] == 1'b0)
			lead--;
		if (lead > int'(fau_pkg::FracBits)) begin
			rm = rm >> (lead - int'(fau_pkg::FracBits));
			re = re + lead - int'(fau_pkg::FracBits);
		end else begin
			rm = rm << (int'(fau_pkg::FracBits) - lead);
			re = re - (int'(fau_pkg::FracBits) - lead);
		end
		biased = re + int'(fau_pkg::ExpBias);
		if (biased > 255) begin
			field = 8'hff;
			res.status = fau_pkg::STATUS_OVER;
		end else if (biased < 0) begin
			field = 8'h00;
			res.status = fau_pkg::STATUS_UNDER;
		end else begin
			field = biased[7:0];
			res.status = fau_pkg::STATUS_OK;
		end
		res.bits = {rs, field, rm[22:0]};
		return res;
	endfunction

	assign pending = expected_q.size();

	initial fail_count = 0;

	// Predict on each accepted beat, compare on each result strobe
	always @(posedge clk) begin
		fp_result_t exp_r;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result bits=%h status=%0d", $time,
						result_bits, range_status);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (result_bits !== exp_r.bits) begin
						$display("%0t: result_bits expected %h actual %h", $time,
							exp_r.bits, result_bits);
						fail_count++;
					end
					if (range_status !== exp_r.status) begin
						$display("%0t: range_status expected %0d actual %0d", $time,
							exp_r.status, range_status);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(fp_compute(req_type, left_bits, right_bits));
		end
	end
endmodule

[sim/tb_top.sv]
// Testbench top: drives add/multiply operations into the unit and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        req_type = 1'b0;
	logic [31:0] left_bits = 32'd0;
	logic [31:0] right_bits = 32'd0;
	wire         busy;
	wire         result_valid;
	wire  [31:0] result_bits;
	wire  [1:0]  range_status;
	int          fail_count;
	int          pending;

	always #5 clk = ~clk;

	float32_add_multiply_unit_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .left_bits(left_bits), .right_bits(right_bits),
		.result_valid(result_valid), .result_bits(result_bits),
		.range_status(range_status)
	);

	fau_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .left_bits(left_bits), .right_bits(right_bits),
		.result_valid(result_valid), .result_bits(result_bits),
		.range_status(range_status), .fail_count(fail_count), .pending(pending)
	);

	// Send one beat; gap cycles idle before it, start held high across back-to-back beats
	task automatic send_op(logic op, logic [31:0] a, logic [31:0] b, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= op;
		left_bits <= a;
		right_bits <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Random operand: moderate exponents half the time, near the extremes otherwise
	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 3))
			0: v[30:23] = 8'($urandom_range(0, 8));
			1: v[30:23] = 8'($urandom_range(247, 255));
			default: v[30:23] = 8'($urandom_range(100, 154));
		endcase
		return v;
	endfunction

	function automatic int rand_gap(logic burst);
		return burst ? 0 : int'($urandom_range(0, 17));
	endfunction

	initial begin
		logic [31:0] a;
		logic        burst;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, cancellation, ties, big shifts, over/underflow
		send_op(fau_pkg::REQ_ADD, 32'h0000_0000, 32'h0000_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'hffff_ffff, 32'hffff_ffff, 0);
		send_op(fau_pkg::REQ_MUL, 32'hffff_ffff, 32'hffff_ffff, 1);
		send_op(fau_pkg::REQ_MUL, 32'h0000_0000, 32'h0000_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'h3f80_0000, 32'hbf80_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'hc040_0000, 32'h4040_0000, 2);
		send_op(fau_pkg::REQ_ADD, 32'h3fc0_0000, 32'h3fa0_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'hbfa0_0000, 32'h3fc0_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'h7f00_0000, 32'h0080_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'h4f80_0000, 32'h3f80_0000, 3);
		send_op(fau_pkg::REQ_ADD, 32'h4b80_0000, 32'h3f80_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'h7f7f_ffff, 32'h7f7f_ffff, 0);
		send_op(fau_pkg::REQ_ADD, 32'h0080_0000, 32'h8080_0001, 0);
		send_op(fau_pkg::REQ_MUL, 32'h7f00_0000, 32'h7f00_0000, 0);
		send_op(fau_pkg::REQ_MUL, 32'h0080_0000, 32'h0080_0000, 0);
		send_op(fau_pkg::REQ_MUL, 32'h3f80_0000, 32'hbf80_0000, 5);
		send_op(fau_pkg::REQ_MUL, 32'h3fff_ffff, 32'h3fff_ffff, 0);
		send_op(fau_pkg::REQ_MUL, 32'h7fff_ffff, 32'h0000_0000, 0);
		send_op(fau_pkg::REQ_ADD, 32'h7fff_ffff, 32'h0000_0000, 0);

		// Random: stretches of bursts or of gapped beats, chosen at random
		for (int i = 0; i < 500; i++) begin
			if (i % 40 == 0)
				burst = logic'($urandom_range(0, 1));
			a = rand_operand();
			case ($urandom_range(0, 7))
				// same magnitude, opposite sign: cancellation
				0: send_op(fau_pkg::REQ_ADD, a, a ^ 32'h8000_0000, rand_gap(burst));
				// close exponents, opposite sign: heavy renormalization
				1: send_op(fau_pkg::REQ_ADD, a, {~a[31], a[30:23], 23'(int'($urandom))},
					rand_gap(burst));
				default: send_op(logic'($urandom_range(0, 1)), a, rand_operand(),
					rand_gap(burst));
			endcase
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
